>>> hw/rtl/prb_pkg.sv
// Package: shared types and constants for the packet reorder buffer
`timescale 1ns / 1ps
package prb_pkg;
  localparam int unsigned HoldDepth  = 5;
  localparam int unsigned MaxPackets = 1024;
  localparam int unsigned HandleBits = 8;
  localparam int unsigned CntW  = 11;
  localparam int unsigned SeqW  = 10;
  localparam int unsigned LenW  = 11;
  localparam int unsigned HdlW  = 8;
  localparam int unsigned OffW  = 21;
  localparam logic [CntW-1:0] ChunkReset = 11'd1380;

  localparam logic [1:0] EvRelease  = 2'd0;
  localparam logic [1:0] EvHeld     = 2'd1;
  localparam logic [1:0] EvDropBad  = 2'd2;
  localparam logic [1:0] EvDropFull = 2'd3;

  localparam logic RegExpectedCount = 1'b0;
  localparam logic RegChunkSize     = 1'b1;

  typedef struct packed {
    logic signed [31:0] seq_number;
    logic [LenW-1:0]    payload_length;
    logic [HdlW-1:0]    payload_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      event_kind;
    logic [SeqW-1:0] out_seq;
    logic [LenW-1:0] out_length;
    logic [HdlW-1:0] out_handle;
    logic [OffW-1:0] write_offset;
    logic            last_of_run;
    logic            all_received;
  } out_item_t;

  // one held descriptor, passed between neighbouring cells
  typedef struct packed {
    logic            vld;
    logic [CntW-1:0] seq;
    logic [LenW-1:0] len;
    logic [HdlW-1:0] hdl;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic            load;   // take new entry when cell is first free one
    logic            chk;    // compare against target this cycle
    logic            pop;    // remove the matched entry, shift from right
    logic [CntW-1:0] target;
  } cell_ctl_t;
endpackage

>>> hw/rtl/prb_cell.sv
// Hold cell: one entry of the hold chain with match and shift logic
`timescale 1ns / 1ps
module prb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prb_pkg::cell_ctl_t ctl_i,
  input  prb_pkg::entry_t    new_i,     // entry to be loaded
  input  logic               left_vld_i,
  input  logic               left_hit_i, // a cell to the left already matched
  input  prb_pkg::entry_t    right_i,
  output prb_pkg::entry_t    ent_o,
  output logic               hit_o,      // this cell or one to the left matched
  output logic               my_hit_o
);
  prb_pkg::entry_t ent_q, ent_d;

  assign my_hit_o = ctl_i.chk && ent_q.vld && (ent_q.seq == ctl_i.target) && !left_hit_i;
  assign hit_o    = left_hit_i || my_hit_o;
  assign ent_o    = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load && left_vld_i && !ent_q.vld) begin
      ent_d = new_i;
    end else if (ctl_i.pop && hit_o) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end
endmodule

>>> hw/rtl/prb_chain.sv
// Hold chain: row of hold cells with ripple match and left shift
`timescale 1ns / 1ps
module prb_chain #(
  parameter int unsigned HoldDepth = prb_pkg::HoldDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prb_pkg::cell_ctl_t ctl_i,
  input  prb_pkg::entry_t    new_i,
  output logic               full_o,
  output logic               hit_o,
  output prb_pkg::entry_t    hit_ent_o
);
  prb_pkg::entry_t ent [HoldDepth];
  logic [HoldDepth:0] hit_c;
  logic [HoldDepth-1:0] my_hit;
  logic [HoldDepth-1:0] vld;

  assign hit_c[0] = 1'b0;

  for (genvar g = 0; g < HoldDepth; g++) begin : g_cell
    prb_pkg::entry_t right;
    logic left_vld;
    if (g == HoldDepth - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = ent[g+1];
    end
    if (g == 0) begin : g_first
      assign left_vld = 1'b1;
    end else begin : g_rest
      assign left_vld = ent[g-1].vld;
    end
    prb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .new_i      (new_i),
      .left_vld_i (left_vld),
      .left_hit_i (hit_c[g]),
      .right_i    (right),
      .ent_o      (ent[g]),
      .hit_o      (hit_c[g+1]),
      .my_hit_o   (my_hit[g])
    );
    assign vld[g] = ent[g].vld;
  end

  assign full_o = vld[HoldDepth-1];
  assign hit_o  = hit_c[HoldDepth];

  always_comb begin
    hit_ent_o = '0;
    for (int i = 0; i < HoldDepth; i++) begin
      if (my_hit[i]) hit_ent_o = ent[i];
    end
  end
endmodule

>>> hw/rtl/packet_reorder_buffer.sv
// Top level: packet reorder buffer with seen bitmap and hold chain
// Path: item registered at start, seen bitmap read, decision, then staged; one result per cycle.
// Items do not overlap: a new item is taken only when idle, after the seen-bitmap read and
//   the flush, which releases each matching held entry (up to HoldDepth).
// Reset: clearing pass over every seen-bitmap entry, busy high.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module packet_reorder_buffer #(
  parameter int unsigned HoldDepth  = prb_pkg::HoldDepth,
  parameter int unsigned MaxPackets = prb_pkg::MaxPackets,
  parameter int unsigned HandleBits = prb_pkg::HandleBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  prb_pkg::in_item_t     in_item_i,
  output logic                  res_strobe_o,
  output prb_pkg::out_item_t    res_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [prb_pkg::CntW-1:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MaxPackets);
  localparam int unsigned CW = prb_pkg::CntW;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StDec   = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;
  localparam logic [2:0] StMul   = 3'd5;

  logic [2:0] st_q, st_d;
  logic [CW-1:0] exp_q, chunk_q, next_q, rcv_q;
  logic [AW:0] clr_q;
  logic seen_mem [MaxPackets];
  logic seen_rd_q;
  prb_pkg::in_item_t it_q;
  prb_pkg::cell_ctl_t ctl;
  prb_pkg::entry_t new_ent, hit_ent;
  logic full, hit;
  logic [CW-1:0] limit;
  logic bad;
  logic [CW-1:0] mseq_q;
  logic [prb_pkg::LenW-1:0] mlen_q;
  logic [prb_pkg::HdlW-1:0] mhdl_q;
  logic mlast_q;

  assign cfg_ready_o = 1'b1;
  assign busy = (st_q != StIdle);
  assign limit = (exp_q > CW'(MaxPackets)) ? CW'(MaxPackets) : exp_q;
  assign bad = it_q.seq_number[31] || (it_q.seq_number >= $signed({21'd0, limit}))
               || seen_rd_q;

  assign new_ent.vld = 1'b1;
  assign new_ent.seq = it_q.seq_number[CW-1:0];
  assign new_ent.len = it_q.payload_length;
  assign new_ent.hdl = it_q.payload_handle & prb_pkg::HdlW'((1 << HandleBits) - 1);

  always_comb begin
    ctl.load   = (st_q == StDec) && !bad && (it_q.seq_number[CW-1:0] != next_q);
    ctl.chk    = (st_q == StFlush);
    ctl.pop    = (st_q == StFlush);
    ctl.target = next_q;
  end

  prb_chain #(.HoldDepth(HoldDepth)) u_chain (
    .clk_i, .rst_ni, .ctl_i(ctl), .new_i(new_ent),
    .full_o(full), .hit_o(hit), .hit_ent_o(hit_ent)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == StClear) begin
      seen_mem[clr_q[AW-1:0]] <= 1'b0;
    end else if (st_q == StDec && !bad) begin
      seen_mem[it_q.seq_number[AW-1:0]] <= 1'b1;
    end
    seen_rd_q <= seen_mem[it_q.seq_number[AW-1:0]];
    if (start && !busy) it_q <= in_item_i;
  end

  // result staging: descriptor then registered multiply
  logic ev_vld_q, out_vld_q;
  logic [1:0] ev_kind_q;
  always_comb begin
    st_d = st_q;
    case (st_q)
      StClear: if (clr_q == (AW+1)'(MaxPackets - 1)) st_d = StIdle;
      StIdle:  if (start) st_d = StRead;
      StRead:  st_d = StDec;
      StDec:   begin
        if (!bad && it_q.seq_number[CW-1:0] == next_q) st_d = StFlush;
        else st_d = StMul;
      end
      StFlush: if (!hit) st_d = StMul;
      StMul:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; exp_q <= '0; chunk_q <= prb_pkg::ChunkReset;
      next_q <= '0; rcv_q <= '0; ev_vld_q <= 1'b0; out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        if (cfg_index_i == prb_pkg::RegExpectedCount) exp_q <= cfg_data_i;
        else chunk_q <= cfg_data_i;
      end
      ev_vld_q <= 1'b0;
      if (st_q == StDec) begin
        ev_vld_q <= 1'b1;
        if (!bad) begin
          rcv_q <= rcv_q + 1'b1;
          if (it_q.seq_number[CW-1:0] == next_q) next_q <= next_q + 1'b1;
        end
      end else if (st_q == StFlush && hit) begin
        ev_vld_q <= 1'b1;
        next_q <= next_q + 1'b1;
      end
      out_vld_q <= ev_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StDec) begin
      mseq_q <= it_q.seq_number[CW-1:0];
      mlen_q <= it_q.payload_length;
      mhdl_q <= new_ent.hdl;
      if (bad) ev_kind_q <= prb_pkg::EvDropBad;
      else if (it_q.seq_number[CW-1:0] == next_q) ev_kind_q <= prb_pkg::EvRelease;
      else if (full) ev_kind_q <= prb_pkg::EvDropFull;
      else ev_kind_q <= prb_pkg::EvHeld;
      mlast_q <= bad || (it_q.seq_number[CW-1:0] != next_q);
    end else begin
      mseq_q <= hit_ent.seq; mlen_q <= hit_ent.len; mhdl_q <= hit_ent.hdl;
      ev_kind_q <= prb_pkg::EvRelease;
      mlast_q <= 1'b0;
    end
  end

  // last flag: flush miss (or non-release) ends the run; patch in output stage
  logic [2*CW-1:0] prod;
  assign prod = mseq_q * chunk_q;
  logic end_now;
  assign end_now = (st_q == StFlush) && !hit;

  // output register; a release is last when the flush finds no match
  always_ff @(posedge clk_i) begin
    res_item_o.event_kind   <= ev_kind_q;
    res_item_o.out_seq      <= mseq_q[prb_pkg::SeqW-1:0];
    res_item_o.out_length   <= mlen_q;
    res_item_o.out_handle   <= mhdl_q;
    res_item_o.write_offset <= (ev_kind_q == prb_pkg::EvRelease) ?
                               prod[prb_pkg::OffW-1:0] : '0;
    res_item_o.last_of_run  <= mlast_q || end_now;
    res_item_o.all_received <= (rcv_q == limit);
  end
  assign res_strobe_o = out_vld_q;
endmodule

>>> hw/rtl/prb_checker.sv
// Checker: port-level assertions for the packet reorder buffer
`timescale 1ns / 1ps
module prb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_strobe_o,
  input prb_pkg::out_item_t res_item_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && $past(!busy) && $past(!busy, 2) |-> !res_strobe_o)
    else $error("result while idle");
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_item_o.event_kind != prb_pkg::EvRelease
    |-> res_item_o.write_offset == '0) else $error("offset on non-release");
endmodule

bind packet_reorder_buffer prb_checker u_prb_checker (
  .clk_i, .rst_ni, .start, .busy, .res_strobe_o, .res_item_o
);
